// File: rtl/key_matrix_debouncer_assert.svh
// ---------------------------------------------------------------------------
// Key matrix debouncer assertion macros
// Shorthand for clocked assertions with reset disable.
// ---------------------------------------------------------------------------
`ifndef KEY_MATRIX_DEBOUNCER_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define KMD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define KMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/kmd_pkg.sv
// ---------------------------------------------------------------------------
// Key matrix debouncer package
// Shared sizes, payload types and event codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kmd_pkg;

	localparam int KEY_COUNT = 10;
	localparam int KEY_IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int KEY_W     = 4;
	localparam int STAMP_W   = 32;
	localparam int DEB_W     = 16;
	localparam int EVENT_W   = 2;

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [STAMP_W-1:0] stamp_t;
	typedef logic [DEB_W-1:0]   deb_t;

	localparam deb_t DEBOUNCE_RESET = 16'd20;

	typedef enum logic [EVENT_W-1:0] {
		EV_NONE     = 2'd0,
		EV_PRESSED  = 2'd1,
		EV_RELEASED = 2'd2
	} event_t;

endpackage

`default_nettype wire

// File: rtl/kmd_ifs.sv
// ---------------------------------------------------------------------------
// Key matrix debouncer interfaces
// Sample, event and configuration channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kmd_sample_if;
	import kmd_pkg::*;
	logic   valid;
	logic   ready;
	key_t   key_index;
	logic   raw_pressed;
	stamp_t time_now;
	modport source (output valid, key_index, raw_pressed, time_now, input ready);
	modport sink (input valid, key_index, raw_pressed, time_now, output ready);
endinterface

interface kmd_event_if;
	import kmd_pkg::*;
	logic               valid;
	logic               ready;
	key_t               result_key;
	logic [EVENT_W-1:0] key_event;
	logic               stable_pressed;
	modport source (output valid, result_key, key_event, stable_pressed, input ready);
	modport sink (input valid, result_key, key_event, stable_pressed, output ready);
endinterface

interface kmd_cfg_if;
	import kmd_pkg::*;
	logic valid;
	logic ready;
	deb_t data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/key_matrix_debouncer.sv
// ---------------------------------------------------------------------------
// Key matrix debouncer
// Items pass the s1 and s2 registers; the key record read-modify-write is in s1.
// Throughput: one item per cycle while the event channel does not stall.
// Reset clears all key records to released and the debounce time to 20 ms.
// Per-key debounce with candidate level, candidate start time and stable level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_debouncer (
	input  logic         clk,
	input  logic         arst_n,
	kmd_sample_if.sink   samples,
	kmd_event_if.source  events,
	kmd_cfg_if.sink      cfg
);
	import kmd_pkg::*;

	deb_t                 debounce_q;
	logic [KEY_COUNT-1:0] cand_level_q;
	logic [KEY_COUNT-1:0] stable_level_q;
	stamp_t               cand_start_q [KEY_COUNT];

	logic   s1_valid;
	key_t   key_s1;
	logic   raw_s1;
	stamp_t now_s1;

	logic   s2_valid;
	key_t   key_s2;
	event_t event_s2;
	logic   stable_s2;

	logic                 s2_free;
	logic                 s1_move;
	logic                 in_range;
	logic [KEY_IDX_W-1:0] idx;
	logic                 cand_lvl;
	logic                 stab_lvl;
	stamp_t               elapsed;
	logic                 held;
	logic                 upd_cand;
	logic                 flip;
	event_t               ev_next;
	logic                 level_next;

	assign s2_free       = !s2_valid || events.ready;
	assign s1_move       = s1_valid && s2_free;
	assign samples.ready = !s1_valid || s2_free;
	assign cfg.ready     = 1'b1;

	assign in_range = 32'(key_s1) < KEY_COUNT;
	assign idx      = key_s1[KEY_IDX_W-1:0];
	assign cand_lvl = cand_level_q[idx];
	assign stab_lvl = stable_level_q[idx];
	assign elapsed  = now_s1 - cand_start_q[idx];
	assign held     = elapsed >= {{(STAMP_W-DEB_W){1'b0}}, debounce_q};

	always_comb begin
		upd_cand   = 1'b0;
		flip       = 1'b0;
		ev_next    = EV_NONE;
		level_next = 1'b0;
		if (in_range) begin
			if (raw_s1 != cand_lvl) begin
				upd_cand = 1'b1;
			end else if (raw_s1 != stab_lvl && held) begin
				flip    = 1'b1;
				ev_next = raw_s1 ? EV_PRESSED : EV_RELEASED;
			end
			level_next = flip ? raw_s1 : stab_lvl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			debounce_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_level_q   <= '0;
			stable_level_q <= '0;
			for (int k = 0; k < KEY_COUNT; k++) begin
				cand_start_q[k] <= '0;
			end
		end else if (s1_move) begin
			if (upd_cand) begin
				cand_level_q[idx] <= raw_s1;
				cand_start_q[idx] <= now_s1;
			end
			if (flip) begin
				stable_level_q[idx] <= raw_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
		end else begin
			if (samples.ready) begin
				s1_valid <= samples.valid;
			end
			if (s2_free) begin
				s2_valid <= s1_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			key_s1 <= samples.key_index;
			raw_s1 <= samples.raw_pressed;
			now_s1 <= samples.time_now;
		end
		if (s1_move) begin
			key_s2    <= key_s1;
			event_s2  <= ev_next;
			stable_s2 <= level_next;
		end
	end

	assign events.valid          = s2_valid;
	assign events.result_key     = key_s2;
	assign events.key_event      = event_s2;
	assign events.stable_pressed = stable_s2;

endmodule

`default_nettype wire

// File: rtl/kmd_checker.sv
// ---------------------------------------------------------------------------
// Key matrix debouncer checker
// Port-level assertions on the event channel, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "key_matrix_debouncer_assert.svh"

module kmd_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  ev_valid,
	input logic                  ev_ready,
	input kmd_pkg::key_t         ev_key,
	input logic [kmd_pkg::EVENT_W-1:0] ev_event,
	input logic                  ev_stable
);
	import kmd_pkg::*;

	`KMD_ASSERT_NEXT(a_hold_stalled, ev_valid && !ev_ready, ev_valid && $stable(ev_key) && $stable(ev_event) && $stable(ev_stable), "Stalled item changed")

	`KMD_ASSERT_NOW(a_press_level, ev_valid && ev_event == EV_PRESSED, ev_stable, "Press event with released level")

	`KMD_ASSERT_NOW(a_release_level, ev_valid && ev_event == EV_RELEASED, !ev_stable, "Release event with pressed level")

	`KMD_ASSERT_NOW(a_bad_key_quiet, ev_valid && 32'(ev_key) >= KEY_COUNT, ev_event == EV_NONE && !ev_stable, "Out of range key reported activity")

endmodule

bind key_matrix_debouncer kmd_checker u_kmd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.ev_valid  (events.valid),
	.ev_ready  (events.ready),
	.ev_key    (events.result_key),
	.ev_event  (events.key_event),
	.ev_stable (events.stable_pressed)
);

`default_nettype wire

// File: tb/tb_key_matrix_debouncer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Key matrix debouncer testbench
// Sends key samples and compares every event item with a per-key debounce
// predictor kept in the bench. It starts with directed cases: reset timing,
// out-of-range keys, time wrap, and zero and maximum debounce times. Random
// scan traffic then follows under several debounce settings. Both sides
// idle at random.
// ---------------------------------------------------------------------------

module tb_key_matrix_debouncer;
	import kmd_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_TICKS = 4;
	localparam int PHASE_ITEMS  = 75;

	typedef struct packed {
		key_t   key_id;
		event_t ev;
		logic   level;
	} key_report_t;

	logic clk = 1'b0;
	logic arst_n;

	kmd_sample_if samples_ch ();
	kmd_event_if  events_ch ();
	kmd_cfg_if    cfg_ch ();

	key_matrix_debouncer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.events  (events_ch),
		.cfg     (cfg_ch)
	);

	deb_t   debounce_ms;
	logic   cand_level [KEY_COUNT];
	stamp_t cand_start [KEY_COUNT];
	logic   stable_level [KEY_COUNT];

	key_report_t expected_events [$];

	bit          smp_quiet;
	bit          evt_quiet;
	int          smp_gap;
	int unsigned mismatches;
	int unsigned cycle_count;
	int unsigned items_sent;
	int unsigned stray_keys;
	int unsigned press_count;
	int unsigned release_count;
	int unsigned settings_written;

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped at cycle limit, %0d events still outstanding",
				expected_events.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int draw_wait(input bit quiet);
		if (quiet || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	function automatic key_report_t debounce_step(input key_t key, input logic raw,
			input stamp_t now);
		key_report_t r;
		stamp_t      held;
		r.key_id = key;
		r.ev     = EV_NONE;
		r.level  = 1'b0;
		if (key < KEY_COUNT) begin
			if (raw != cand_level[key]) begin
				cand_level[key] = raw;
				cand_start[key] = now;
			end else if (raw != stable_level[key]) begin
				held = now - cand_start[key];
				if (held >= stamp_t'(debounce_ms)) begin
					stable_level[key] = raw;
					r.ev = raw ? EV_PRESSED : EV_RELEASED;
				end
			end
			r.level = stable_level[key];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < 40)
			$display("Mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic send_sample(input key_t key, input logic raw, input stamp_t now);
		if (smp_gap > 0) begin
			samples_ch.valid <= 1'b0;
			repeat (smp_gap) @(posedge clk);
		end
		samples_ch.valid       <= 1'b1;
		samples_ch.key_index   <= key;
		samples_ch.raw_pressed <= raw;
		samples_ch.time_now    <= now;
		do @(posedge clk); while (!samples_ch.ready);
		expected_events.push_back(debounce_step(key, raw, now));
		items_sent++;
		if (key >= KEY_COUNT)
			stray_keys++;
		smp_gap = draw_wait(smp_quiet);
	endtask

	task automatic drain();
		samples_ch.valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_debounce(input deb_t value);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		debounce_ms = value;
		settings_written++;
	endtask

	always @(posedge clk) begin : event_check
		key_report_t want;
		if (arst_n && events_ch.valid && events_ch.ready) begin
			if (expected_events.size() == 0) begin
				report_mismatch($sformatf("unexpected event item for key %0d",
					events_ch.result_key));
			end else begin
				want = expected_events.pop_front();
				if (events_ch.result_key !== want.key_id)
					report_mismatch($sformatf("result_key %0d, expected %0d",
						events_ch.result_key, want.key_id));
				if (events_ch.key_event !== want.ev)
					report_mismatch($sformatf("key %0d: key_event %0d, expected %0d",
						want.key_id, events_ch.key_event, want.ev));
				if (events_ch.stable_pressed !== want.level)
					report_mismatch($sformatf("key %0d: stable_pressed %0b, expected %0b",
						want.key_id, events_ch.stable_pressed, want.level));
				if (want.ev == EV_PRESSED)
					press_count++;
				if (want.ev == EV_RELEASED)
					release_count++;
			end
		end
	end

	initial begin : event_ready
		int stall;
		events_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(evt_quiet);
			if (stall > 0) begin
				events_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			events_ch.ready <= 1'b1;
			do @(posedge clk); while (!events_ch.valid);
		end
	end

	task automatic test_reset_timing();
		send_sample(4'd0, 1'b1, 32'd0);
		send_sample(4'd0, 1'b1, 32'd19);
		send_sample(4'd0, 1'b1, 32'd20);
		send_sample(4'd0, 1'b1, 32'd25);
		send_sample(4'd0, 1'b0, 32'd100);
		send_sample(4'd0, 1'b0, 32'd120);
		send_sample(4'd3, 1'b0, 32'hFFFF_FFFF);
	endtask

	task automatic test_stray_keys();
		send_sample(4'd10, 1'b1, 32'd5);
		send_sample(4'd15, 1'b1, 32'hFFFF_FFFF);
		send_sample(4'd15, 1'b0, 32'd0);
		send_sample(4'd9, 1'b1, 32'd50);
	endtask

	task automatic test_time_wrap();
		send_sample(4'd5, 1'b1, 32'hFFFF_FFF0);
		send_sample(4'd5, 1'b1, 32'h0000_0004);
	endtask

	task automatic test_zero_debounce();
		write_debounce(16'd0);
		send_sample(4'd2, 1'b1, 32'd7);
		send_sample(4'd2, 1'b1, 32'd7);
		send_sample(4'd2, 1'b0, 32'd7);
		send_sample(4'd2, 1'b0, 32'd7);
	endtask

	task automatic test_max_debounce();
		write_debounce(16'hFFFF);
		send_sample(4'd7, 1'b1, 32'd1000);
		send_sample(4'd7, 1'b1, 32'd1000 + 32'd65534);
		send_sample(4'd7, 1'b1, 32'd1000 + 32'd65535);
	endtask

	task automatic test_random_scan();
		deb_t        settings [6];
		stamp_t      clock_ms;
		int unsigned span;
		key_t        key;
		logic        raw;
		settings = '{16'd0, 16'd1, DEBOUNCE_RESET, 16'hFFFF,
			deb_t'($urandom_range(2, 200)), deb_t'($urandom)};
		for (int phase = 0; phase < 6; phase++) begin
			write_debounce(settings[phase]);
			smp_quiet = (phase % 2 == 1);
			evt_quiet = (phase / 2 == 1);
			clock_ms  = $urandom;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 4 && n == PHASE_ITEMS / 2)
					drain();
				if ($urandom_range(0, 9) == 0)
					key = key_t'($urandom_range(KEY_COUNT, 15));
				else
					key = key_t'($urandom_range(0, KEY_COUNT - 1));
				span = int'(debounce_ms) + 1;
				case ($urandom_range(0, 19))
					0: clock_ms = $urandom;
					1, 2, 3: clock_ms += $urandom_range(span, 2 * span);
					default: clock_ms += $urandom_range(0, span / 4 + 2);
				endcase
				if (key < KEY_COUNT && $urandom_range(0, 9) < 7)
					raw = cand_level[key];
				else
					raw = 1'($urandom_range(0, 1));
				send_sample(key, raw, clock_ms);
			end
		end
	endtask

	initial begin
		arst_n                 <= 1'b0;
		samples_ch.valid       <= 1'b0;
		samples_ch.key_index   <= '0;
		samples_ch.raw_pressed <= 1'b0;
		samples_ch.time_now    <= '0;
		cfg_ch.valid           <= 1'b0;
		cfg_ch.data            <= '0;
		debounce_ms = DEBOUNCE_RESET;
		for (int k = 0; k < KEY_COUNT; k++) begin
			cand_level[k]   = 1'b0;
			cand_start[k]   = '0;
			stable_level[k] = 1'b0;
		end
		smp_quiet = 1'b0;
		evt_quiet = 1'b0;
		smp_gap   = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_timing();
		test_stray_keys();
		test_time_wrap();
		test_zero_debounce();
		test_max_debounce();
		test_random_scan();
		drain();

		$display("Covered %0d key samples, %0d of them with an out-of-range key index.",
			items_sent, stray_keys);
		$display("Saw %0d press and %0d release events across %0d debounce settings.",
			press_count, release_count, settings_written + 1);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/kmd_pkg.sv
rtl/kmd_ifs.sv
rtl/key_matrix_debouncer.sv
rtl/kmd_checker.sv
tb/tb_key_matrix_debouncer.sv
